>>> design/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg: shared types and constants for the LCD nibble write sequencer
// Register map, reset values, queue entry and status structs.
// ----------------------------------------------------------------------------
`default_nettype none

package lcdnw_pkg;

   localparam int unsigned QueueDepth = 2;
   localparam int unsigned AddrW      = 5;
   localparam int unsigned DataW      = 32;

   localparam logic [15:0] HoldMax = 16'hFFFF;

   localparam logic [15:0] SelectSetupReset = 16'd1000;
   localparam logic [15:0] EnablePhaseReset = 16'd10;
   localparam logic [15:0] ByteGapReset     = 16'd100;
   localparam logic [15:0] SlowCommandReset = 16'd1070;
   localparam logic [15:0] FastCommandReset = 16'd40;
   localparam logic [15:0] DataDoneReset    = 16'd1000;
   localparam logic [7:0]  SlowLimitReset   = 8'd4;

   typedef enum logic [2:0] {
      REG_SELECT_SETUP = 3'd0,
      REG_ENABLE_PHASE = 3'd1,
      REG_BYTE_GAP     = 3'd2,
      REG_SLOW_COMMAND = 3'd3,
      REG_FAST_COMMAND = 3'd4,
      REG_DATA_DONE    = 3'd5,
      REG_SLOW_LIMIT   = 3'd6,
      REG_UNUSED       = 3'd7
   } reg_idx_type;

   typedef struct packed {
      logic [15:0] select_setup_us;
      logic [15:0] enable_phase_us;
      logic [15:0] byte_gap_us;
      logic [15:0] slow_command_us;
      logic [15:0] fast_command_us;
      logic [15:0] data_done_us;
      logic [7:0]  slow_code_limit;
   } cfg_type;

   // one classified byte, as queued between front and back
   typedef struct packed {
      logic        sel;
      logic [3:0]  prev_nibble;
      logic [3:0]  hi_nibble;
      logic [3:0]  lo_nibble;
      logic [15:0] last_hold;
   } entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   typedef enum logic [6:0] {
      PH_SETUP   = 7'b000_0001,
      PH_HI_LOW  = 7'b000_0010,
      PH_HI_HIGH = 7'b000_0100,
      PH_HI_TAIL = 7'b000_1000,
      PH_LO_LOW  = 7'b001_0000,
      PH_LO_HIGH = 7'b010_0000,
      PH_LO_TAIL = 7'b100_0000
   } phase_type;

   function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[16] ? HoldMax : s[15:0];
   endfunction

endpackage

`default_nettype wire

>>> design/char_lcd_nibble_write_sequencer_core.sv
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer_core: 4-bit character LCD byte writer
// Turns command or data bytes into seven timed pin phases per byte.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  req      | req_valid/req_stall  | req_code[7:0], req_is_data
//  rsp      | rsp_valid/rsp_stall  | select, enable, data_pins[3:0],
//           |                      | hold_us[15:0], last_phase
//  csr      | psel/penable/pready  | paddr[4:0], pwdata/prdata[31:0]
//
//  Each byte yields seven results, one per cycle while rsp_stall is low; the
//  phase sequencer in the back end sets the rate, bytes back to back.
//  The first result of a byte passes through the queue entry and then the
//  result register after the byte is accepted.
//  Synchronous active-high reset clears queue, phase state and held nibble;
//  registers return to their documented defaults.
//  A stalled result holds; the queue keeps taking bytes until it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module char_lcd_nibble_write_sequencer_core #(
   parameter int unsigned QueueDepth = lcdnw_pkg::QueueDepth
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire  [7:0]                  req_code,
   input  wire                         req_is_data,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_select_pin,
   output logic                        rsp_enable_pin,
   output logic [3:0]                  rsp_data_pins,
   output logic [15:0]                 rsp_hold_us,
   output logic                        rsp_last_phase,
   input  wire                         psel,
   input  wire                         penable,
   input  wire                         pwrite,
   input  wire  [lcdnw_pkg::AddrW-1:0] paddr,
   input  wire  [lcdnw_pkg::DataW-1:0] pwdata,
   output logic [lcdnw_pkg::DataW-1:0] prdata,
   output logic                        pready
);

   lcdnw_pkg::cfg_type          cfg_ff, cfg_in;
   lcdnw_pkg::queue_status_type q_status;
   lcdnw_pkg::entry_type        push_entry;
   lcdnw_pkg::entry_type        head_entry;
   lcdnw_pkg::reg_idx_type      reg_idx;

   logic push;
   logic pop;
   logic csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign reg_idx   = lcdnw_pkg::reg_idx_type'(paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (reg_idx)
            lcdnw_pkg::REG_SELECT_SETUP: cfg_in.select_setup_us = pwdata[15:0];
            lcdnw_pkg::REG_ENABLE_PHASE: cfg_in.enable_phase_us = pwdata[15:0];
            lcdnw_pkg::REG_BYTE_GAP:     cfg_in.byte_gap_us     = pwdata[15:0];
            lcdnw_pkg::REG_SLOW_COMMAND: cfg_in.slow_command_us = pwdata[15:0];
            lcdnw_pkg::REG_FAST_COMMAND: cfg_in.fast_command_us = pwdata[15:0];
            lcdnw_pkg::REG_DATA_DONE:    cfg_in.data_done_us    = pwdata[15:0];
            lcdnw_pkg::REG_SLOW_LIMIT:   cfg_in.slow_code_limit = pwdata[7:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         lcdnw_pkg::REG_SELECT_SETUP: prdata = {16'd0, cfg_ff.select_setup_us};
         lcdnw_pkg::REG_ENABLE_PHASE: prdata = {16'd0, cfg_ff.enable_phase_us};
         lcdnw_pkg::REG_BYTE_GAP:     prdata = {16'd0, cfg_ff.byte_gap_us};
         lcdnw_pkg::REG_SLOW_COMMAND: prdata = {16'd0, cfg_ff.slow_command_us};
         lcdnw_pkg::REG_FAST_COMMAND: prdata = {16'd0, cfg_ff.fast_command_us};
         lcdnw_pkg::REG_DATA_DONE:    prdata = {16'd0, cfg_ff.data_done_us};
         lcdnw_pkg::REG_SLOW_LIMIT:   prdata = {24'd0, cfg_ff.slow_code_limit};
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.select_setup_us <= lcdnw_pkg::SelectSetupReset;
         cfg_ff.enable_phase_us <= lcdnw_pkg::EnablePhaseReset;
         cfg_ff.byte_gap_us     <= lcdnw_pkg::ByteGapReset;
         cfg_ff.slow_command_us <= lcdnw_pkg::SlowCommandReset;
         cfg_ff.fast_command_us <= lcdnw_pkg::FastCommandReset;
         cfg_ff.data_done_us    <= lcdnw_pkg::DataDoneReset;
         cfg_ff.slow_code_limit <= lcdnw_pkg::SlowLimitReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcdnw_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_code   (req_code),
      .req_is_data(req_is_data),
      .cfg        (cfg_ff),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   lcdnw_queue #(
      .Depth(QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_entry(push_entry),
      .pop       (pop),
      .head_entry(head_entry),
      .status    (q_status)
   );

   lcdnw_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .q_status      (q_status),
      .head_entry    (head_entry),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_select_pin(rsp_select_pin),
      .rsp_enable_pin(rsp_enable_pin),
      .rsp_data_pins (rsp_data_pins),
      .rsp_hold_us   (rsp_hold_us),
      .rsp_last_phase(rsp_last_phase)
   );

   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue reports full and empty at once");

   a_enable_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_pin |-> rsp_hold_us == cfg_ff.enable_phase_us)
      else $error("enable-high phase hold differs from enable phase register");

   a_enable_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_pin |-> !rsp_last_phase)
      else $error("final phase drives enable high");

   a_pop_on_last: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid && rsp_last_phase)
      else $error("queue popped without a final phase result");

endmodule

`default_nettype wire

>>> design/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front: input acceptance and byte classification
// Splits the byte into nibbles, picks the completion delay, builds the
// final hold and tracks the level left on the data pins.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_front (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [7:0]                 req_code,
   input  wire                        req_is_data,
   input  lcdnw_pkg::cfg_type         cfg,
   input  lcdnw_pkg::queue_status_type q_status,
   output logic                       push,
   output lcdnw_pkg::entry_type       push_entry
);

   logic [3:0]  held_nibble_ff;
   logic [3:0]  held_nibble_in;
   logic [15:0] done_us;
   logic [15:0] gap_sum;

   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      if (req_is_data) begin
         done_us = cfg.data_done_us;
      end else if (req_code < cfg.slow_code_limit) begin
         done_us = cfg.slow_command_us;
      end else begin
         done_us = cfg.fast_command_us;
      end
   end

   assign gap_sum = lcdnw_pkg::sat_add(cfg.enable_phase_us, cfg.byte_gap_us);

   always_comb begin
      push_entry.sel         = req_is_data;
      push_entry.prev_nibble = held_nibble_ff;
      push_entry.hi_nibble   = req_code[7:4];
      push_entry.lo_nibble   = req_code[3:0];
      push_entry.last_hold   = lcdnw_pkg::sat_add(gap_sum, done_us);
   end

   // the low nibble stays on the pins until the next byte
   assign held_nibble_in = push ? req_code[3:0] : held_nibble_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_nibble_ff <= 4'd0;
      end else begin
         held_nibble_ff <= held_nibble_in;
      end
   end

endmodule

`default_nettype wire

>>> design/lcdnw_queue.sv
// ----------------------------------------------------------------------------
// lcdnw_queue: short queue between front and back
// Register-based circular buffer of classified bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_queue #(
   parameter int unsigned Depth = lcdnw_pkg::QueueDepth
) (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          push,
   input  lcdnw_pkg::entry_type         push_entry,
   input  wire                          pop,
   output lcdnw_pkg::entry_type         head_entry,
   output lcdnw_pkg::queue_status_type  status
);

   localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CntW = $clog2(Depth + 1);

   lcdnw_pkg::entry_type mem_ff [Depth];

   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;

   function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
      return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
   endfunction

   assign status.full  = (count_ff == CntW'(Depth));
   assign status.empty = (count_ff == '0);
   assign head_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CntW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

>>> design/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back: phase sequencer
// Walks the seven bus phases of the head byte into the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lcdnw_back (
   input  wire                         clock,
   input  wire                         reset,
   input  lcdnw_pkg::cfg_type          cfg,
   input  lcdnw_pkg::queue_status_type q_status,
   input  lcdnw_pkg::entry_type        head_entry,
   output logic                        pop,
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic                        rsp_select_pin,
   output logic                        rsp_enable_pin,
   output logic [3:0]                  rsp_data_pins,
   output logic [15:0]                 rsp_hold_us,
   output logic                        rsp_last_phase
);

   lcdnw_pkg::phase_type phase_ff, phase_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic        select_ff, select_in;
   logic        enable_ff, enable_in;
   logic [3:0]  pins_ff, pins_in;
   logic [15:0] hold_ff, hold_in;
   logic        last_ff, last_in;
   logic        advance;
   logic        load;

   // output slot frees when empty or taken this cycle
   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = advance && !q_status.empty;
   assign pop     = load && (phase_ff == lcdnw_pkg::PH_LO_TAIL);

   always_comb begin
      phase_in  = phase_ff;
      select_in = head_entry.sel;
      enable_in = 1'b0;
      pins_in   = head_entry.hi_nibble;
      hold_in   = cfg.enable_phase_us;
      last_in   = 1'b0;
      unique case (phase_ff)
         lcdnw_pkg::PH_SETUP: begin
            pins_in  = head_entry.prev_nibble;
            hold_in  = cfg.select_setup_us;
            phase_in = lcdnw_pkg::PH_HI_LOW;
         end
         lcdnw_pkg::PH_HI_LOW: begin
            phase_in = lcdnw_pkg::PH_HI_HIGH;
         end
         lcdnw_pkg::PH_HI_HIGH: begin
            enable_in = 1'b1;
            phase_in  = lcdnw_pkg::PH_HI_TAIL;
         end
         lcdnw_pkg::PH_HI_TAIL: begin
            phase_in = lcdnw_pkg::PH_LO_LOW;
         end
         lcdnw_pkg::PH_LO_LOW: begin
            pins_in  = head_entry.lo_nibble;
            phase_in = lcdnw_pkg::PH_LO_HIGH;
         end
         lcdnw_pkg::PH_LO_HIGH: begin
            pins_in   = head_entry.lo_nibble;
            enable_in = 1'b1;
            phase_in  = lcdnw_pkg::PH_LO_TAIL;
         end
         lcdnw_pkg::PH_LO_TAIL: begin
            pins_in  = head_entry.lo_nibble;
            hold_in  = head_entry.last_hold;
            last_in  = 1'b1;
            phase_in = lcdnw_pkg::PH_SETUP;
         end
         default: begin
            phase_in = lcdnw_pkg::PH_SETUP;
         end
      endcase
   end

   assign rsp_valid_in = load ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= lcdnw_pkg::PH_SETUP;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (load) begin
            phase_ff <= phase_in;
         end
      end
   end

   // hold the payload while the result waits
   always_ff @(posedge clock) begin
      if (load) begin
         select_ff <= select_in;
         enable_ff <= enable_in;
         pins_ff   <= pins_in;
         hold_ff   <= hold_in;
         last_ff   <= last_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_select_pin = select_ff;
   assign rsp_enable_pin = enable_ff;
   assign rsp_data_pins  = pins_ff;
   assign rsp_hold_us    = hold_ff;
   assign rsp_last_phase = last_ff;

endmodule

`default_nettype wire
